// ===== rtl/indexed_list_store_assert.svh =====
// Assertion macros for the indexed list store RTL, included by the sequencer ils_ctrl.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define ILS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ILS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ils_pkg.sv =====
// Shared types and constants of the indexed list store.
`default_nettype none
package ils_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int DEPTH_DEF = 1024;

	typedef enum logic [2:0] {
		K_APPEND = 3'd0,
		K_READ   = 3'd1,
		K_WRITE  = 3'd2,
		K_REMOVE = 3'd3,
		K_RANGE  = 3'd4,
		K_CLEAR  = 3'd5,
		K_LAST   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_READ
	} state_t;

	// Broadcast controls from the sequencer to every cell.
	typedef struct packed {
		logic wr;       // write wdata into the cell at pos
		logic rd_load;  // tap the word at pos into the read chain
		logic rd_shift; // move the read chain one cell toward cell 0
		logic shift;    // cells at or above pos take the upper neighbor's word
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ils_cell.sv =====
// One storage cell of the list: a word and one stage of the read chain.
`default_nettype none
module ils_cell #(
	parameter int          PW  = 10,
	parameter int unsigned POS = 0
) (
	input  wire                              clk,
	input  ils_pkg::cell_ctl_t               ctl,
	input  wire  [PW-1:0]                    pos,
	input  wire  [ils_pkg::DATA_W-1:0]       wdata,
	input  wire  [ils_pkg::DATA_W-1:0]       word_nxt,
	input  wire  [ils_pkg::DATA_W-1:0]       rd_nxt,
	output logic [ils_pkg::DATA_W-1:0]       word,
	output logic [ils_pkg::DATA_W-1:0]       rd
);

	localparam logic [PW-1:0] MY_POS = PW'(POS);

	logic [ils_pkg::DATA_W-1:0] word_q;
	logic [ils_pkg::DATA_W-1:0] rd_q;
	logic                       hit;
	logic                       above;

	assign hit   = (pos == MY_POS);
	assign above = (pos <= MY_POS);

	always_ff @(posedge clk) begin
		if (ctl.wr && hit) begin
			word_q <= wdata;
		end else if (ctl.shift && above) begin
			word_q <= word_nxt;
		end
	end

	// Load only the selected word, zeros elsewhere, then walk toward cell 0.
	always_ff @(posedge clk) begin
		if (ctl.rd_load) begin
			rd_q <= hit ? word_q : '0;
		end else if (ctl.rd_shift) begin
			rd_q <= rd_nxt;
		end
	end

	assign word = word_q;
	assign rd   = rd_q;

endmodule
`default_nettype wire

// ===== rtl/ils_ctrl.sv =====
// Command sequencer of the list: decode, count, shift and read walk.
`default_nettype none
`include "indexed_list_store_assert.svh"
module ils_ctrl #(
	parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire  [2:0]                      kind,
	input  wire  [ils_pkg::IDX_W-1:0]       index,
	input  wire  [ils_pkg::IDX_W-1:0]       index_end,
	input  wire  [ils_pkg::DATA_W-1:0]      rd_head,
	output ils_pkg::cell_ctl_t              ctl,
	output logic [$clog2(DEPTH)-1:0]        pos,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [ils_pkg::DATA_W-1:0]      read_value,
	output logic [ils_pkg::CNT_W-1:0]       count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);
	localparam int W  = ((CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W) + 1;
	localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

	ils_pkg::state_t            state_q, state_d;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic [CW-1:0]              step_q, step_d;
	logic [PW-1:0]              first_q, first_d;
	logic                       done_q;
	ils_pkg::stat_t             status_q, fin_status;
	logic [ils_pkg::DATA_W-1:0] rd_val_q, fin_rd;
	logic                       fin;

	logic          accept;
	logic [W-1:0]  idx_w, end_w, cnt_w, gap_w;
	logic          in_rng, rng_ok, full;
	logic          go_shift, go_read;
	ils_pkg::kind_t kind_e;

	assign accept = start && (state_q == ils_pkg::S_IDLE);
	assign kind_e = ils_pkg::kind_t'(kind);
	assign idx_w  = W'(index);
	assign end_w  = W'(index_end);
	assign cnt_w  = W'(cnt_q);
	assign gap_w  = end_w - idx_w + W'(1);
	assign in_rng = (idx_w < cnt_w);
	assign rng_ok = (idx_w <= end_w) && (end_w < cnt_w);
	assign full   = (cnt_w >= DEPTH_W);

	always_comb begin
		go_shift = 1'b0;
		go_read  = 1'b0;
		unique case (kind_e)
			ils_pkg::K_READ:   go_read  = in_rng;
			ils_pkg::K_REMOVE: go_shift = in_rng;
			ils_pkg::K_RANGE:  go_shift = rng_ok;
			ils_pkg::K_LAST:   go_read  = (cnt_q != '0);
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ils_pkg::S_IDLE: begin
				if (accept && go_shift) begin
					state_d = ils_pkg::S_SHIFT;
				end else if (accept && go_read) begin
					state_d = ils_pkg::S_READ;
				end
			end
			ils_pkg::S_SHIFT: begin
				if (step_q == CW'(1)) state_d = ils_pkg::S_IDLE;
			end
			ils_pkg::S_READ: begin
				if (step_q == '0) state_d = ils_pkg::S_IDLE;
			end
			default: state_d = ils_pkg::S_IDLE;
		endcase
	end

	// Outputs and datapath updates.
	always_comb begin
		ctl        = '0;
		pos        = first_q;
		fin        = 1'b0;
		fin_status = ils_pkg::ST_OK;
		fin_rd     = '0;
		cnt_d      = cnt_q;
		step_d     = step_q;
		first_d    = first_q;
		unique case (state_q)
			ils_pkg::S_IDLE: begin
				if (accept) begin
					unique case (kind_e)
						ils_pkg::K_APPEND: begin
							fin = 1'b1;
							if (full) begin
								fin_status = ils_pkg::ST_FULL;
							end else begin
								ctl.wr = 1'b1;
								pos    = cnt_q[PW-1:0];
								cnt_d  = cnt_q + CW'(1);
							end
						end
						ils_pkg::K_READ: begin
							if (!in_rng) begin
								fin        = 1'b1;
								fin_status = ils_pkg::ST_RANGE;
							end else begin
								ctl.rd_load = 1'b1;
								pos         = PW'(index);
								step_d      = CW'(index);
							end
						end
						ils_pkg::K_WRITE: begin
							fin = 1'b1;
							if (!in_rng) begin
								fin_status = ils_pkg::ST_RANGE;
							end else begin
								ctl.wr = 1'b1;
								pos    = PW'(index);
							end
						end
						ils_pkg::K_REMOVE: begin
							if (!in_rng) begin
								fin        = 1'b1;
								fin_status = ils_pkg::ST_RANGE;
							end else begin
								first_d = PW'(index);
								step_d  = CW'(1);
							end
						end
						ils_pkg::K_RANGE: begin
							if (!rng_ok) begin
								fin        = 1'b1;
								fin_status = ils_pkg::ST_RANGE;
							end else begin
								first_d = PW'(index);
								step_d  = gap_w[CW-1:0];
							end
						end
						ils_pkg::K_CLEAR: begin
							fin   = 1'b1;
							cnt_d = '0;
						end
						ils_pkg::K_LAST: begin
							if (cnt_q == '0) begin
								fin        = 1'b1;
								fin_status = ils_pkg::ST_EMPTY;
							end else begin
								ctl.rd_load = 1'b1;
								pos         = PW'(cnt_q - CW'(1));
								step_d      = cnt_q - CW'(1);
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ils_pkg::S_SHIFT: begin
				ctl.shift = 1'b1;
				cnt_d     = cnt_q - CW'(1);
				step_d    = step_q - CW'(1);
				fin       = (step_q == CW'(1));
			end
			ils_pkg::S_READ: begin
				if (step_q == '0) begin
					fin    = 1'b1;
					fin_rd = rd_head;
				end else begin
					ctl.rd_shift = 1'b1;
					step_d       = step_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ils_pkg::S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		step_q   <= step_d;
		first_q  <= first_d;
		status_q <= fin_status;
		rd_val_q <= fin_rd;
	end

	assign busy       = (state_q != ils_pkg::S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rd_val_q;
	assign count      = ils_pkg::CNT_W'(cnt_q);

	`ILS_ASSERT_NEXT(a_accept_answers, clk, arst_n, accept, done_q || busy, "request lost")
	`ILS_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, state_q == ils_pkg::S_IDLE, "done while busy")
	`ILS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, cnt_w <= DEPTH_W, "count above depth")
	`ILS_ASSERT_NEXT(a_shift_count, clk, arst_n, state_q == ils_pkg::S_SHIFT, cnt_q == $past(cnt_q) - CW'(1), "shift count slip")

endmodule
`default_nettype wire

// ===== rtl/indexed_list_store.sv =====
// Top level of the indexed list store: sequencer plus a row of word cells.
//
// Usage:
//   Drive kind, index, index_end and value and raise start; the request is
//   taken at the rising edge where start is high and busy is low. Exactly one
//   result follows per request: done pulses high for one cycle with status,
//   read_value and count valid in that same cycle. The receiver cannot stall,
//   so sample the result whenever done is high.
//   Append, write, clear, read last on empty and flagged requests answer
//   straight from idle. A read loads the word into the read chain and walks
//   it to cell 0; a remove shifts the words above it down once per word
//   removed. The read walk and the shifts move one cell per cycle along the
//   row; busy stays high while a walk or shift runs, and a new request may be
//   taken in the cycle that shows done.
//   Reset clears the count and the sequencer; stored words are left
//   undefined, but no position at or above the count is ever read.
`default_nettype none
module indexed_list_store #(
	parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [2:0]                  kind,
	input  wire  [ils_pkg::IDX_W-1:0]   index,
	input  wire  [ils_pkg::IDX_W-1:0]   index_end,
	input  wire  [ils_pkg::DATA_W-1:0]  value,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [ils_pkg::DATA_W-1:0]  read_value,
	output logic [ils_pkg::CNT_W-1:0]   count
);

	localparam int PW = $clog2(DEPTH);

	ils_pkg::cell_ctl_t         ctl;
	logic [PW-1:0]              pos;
	// Index DEPTH is the zero tie-off past the last cell.
	logic [ils_pkg::DATA_W-1:0] word_w [DEPTH+1];
	logic [ils_pkg::DATA_W-1:0] rd_w   [DEPTH+1];

	assign word_w[DEPTH] = '0;
	assign rd_w[DEPTH]   = '0;

	ils_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.index     (index),
		.index_end (index_end),
		.rd_head   (rd_w[0]),
		.ctl       (ctl),
		.pos       (pos),
		.done      (done),
		.status    (status),
		.read_value(read_value),
		.count     (count)
	);

	// Each cell takes writes by position, shifts down from its upper neighbor
	// on removal, and passes the read chain toward cell 0.
	for (genvar p = 0; p < DEPTH; p++) begin : g_cell
		ils_cell #(
			.PW (PW),
			.POS(p)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.pos     (pos),
			.wdata   (value),
			.word_nxt(word_w[p+1]),
			.rd_nxt  (rd_w[p+1]),
			.word    (word_w[p]),
			.rd      (rd_w[p])
		);
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the indexed list store: directed and random requests checked against a predictor.
module tb;
	import ils_pkg::*;

	// Kind code with no operation behind it; the block must ignore it.
	localparam logic [2:0] K_UNUSED = 3'd7;
	localparam int LIST_CAP = DEPTH_DEF;
	// Longest walk or shift is about one cell per cycle across the whole row.
	localparam int SETTLE_CYCLES = LIST_CAP + 80;
	// Keep the random list short so that read walks stay cheap.
	localparam int SOFT_LEN = 80;
	localparam int PRINT_CAP = 40;
	localparam int RUN_LIMIT_NS = 4_000_000;

	typedef struct {
		logic [2:0]        op;
		stat_t             st;
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  len;
	} list_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        kind;
	logic [IDX_W-1:0]  index;
	logic [IDX_W-1:0]  index_end;
	logic [DATA_W-1:0] value;
	logic              done;
	logic [1:0]        status;
	logic [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]  count;

	// Predictor state: the words held and how many of them are live.
	logic [DATA_W-1:0] list_words [0:LIST_CAP-1];
	int                list_len;
	list_result_t      pending_results [$];

	int idle_pct;
	int err_count;
	int requests_sent;
	int results_checked;
	int seen_status [4];

	indexed_list_store #(
		.DEPTH(LIST_CAP)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.index     (index),
		.index_end (index_end),
		.value     (value),
		.done      (done),
		.status    (status),
		.read_value(read_value),
		.count     (count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs or never answers.
	initial begin
		#(RUN_LIMIT_NS);
		$display("[indexed_list_store] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		err_count++;
		if (err_count <= PRINT_CAP) begin
			$display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	// Close the hole left by removing [first, last]: move later words down.
	task automatic close_gap(input int first, input int last);
		int gap;
		int d;
		gap = last - first + 1;
		for (d = first; d + gap < list_len; d++) begin
			list_words[d] = list_words[d + gap];
		end
		list_len -= gap;
	endtask

	// Work out the one result of a request and update the predicted list.
	task automatic apply_list_cmd(input logic [2:0] op, input logic [IDX_W-1:0] at,
			input logic [IDX_W-1:0] at_end, input logic [DATA_W-1:0] word,
			output list_result_t res);
		res.op   = op;
		res.st   = ST_OK;
		res.word = '0;
		case (op)
			K_APPEND: begin
				if (list_len >= LIST_CAP) begin
					res.st = ST_FULL;
				end else begin
					list_words[list_len] = word;
					list_len++;
				end
			end
			K_READ: begin
				if (int'(at) >= list_len) res.st = ST_RANGE;
				else res.word = list_words[at];
			end
			K_WRITE: begin
				if (int'(at) >= list_len) res.st = ST_RANGE;
				else list_words[at] = word;
			end
			K_REMOVE: begin
				if (int'(at) >= list_len) res.st = ST_RANGE;
				else close_gap(int'(at), int'(at));
			end
			K_RANGE: begin
				if (at > at_end || int'(at_end) >= list_len) res.st = ST_RANGE;
				else close_gap(int'(at), int'(at_end));
			end
			K_CLEAR: begin
				// Stored words stay; only the count drops.
				list_len = 0;
			end
			K_LAST: begin
				if (list_len == 0) res.st = ST_EMPTY;
				else res.word = list_words[list_len - 1];
			end
			default: ;
		endcase
		res.len = CNT_W'(list_len);
	endtask

	// Offer one request, hold it until the block takes it, then predict its result.
	task automatic send_cmd(input logic [2:0] op, input logic [IDX_W-1:0] at,
			input logic [IDX_W-1:0] at_end, input logic [DATA_W-1:0] word);
		list_result_t res;
		int gap;
		if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			gap = $urandom_range(8, 1);
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start     <= 1'b1;
		kind      <= op;
		index     <= at;
		index_end <= at_end;
		value     <= word;
		// busy read right after the edge is its value before the edge.
		do @(posedge clk); while (busy);
		apply_list_cmd(op, at, at_end, word, res);
		pending_results.push_back(res);
		requests_sent++;
	endtask

	// Drop start and hold off until every predicted result has come back.
	task automatic wait_results_drained();
		@(negedge clk) start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Compare each strobed result with the oldest prediction.
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", '0, {30'd0, status});
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (status !== want.st) begin
					report_mismatch($sformatf("status, kind %0d", want.op),
						DATA_W'(want.st), DATA_W'(status));
				end
				if (read_value !== want.word) begin
					report_mismatch($sformatf("read_value, kind %0d", want.op),
						want.word, read_value);
				end
				if (count !== want.len) begin
					report_mismatch($sformatf("count, kind %0d", want.op),
						DATA_W'(want.len), DATA_W'(count));
				end
				if (!$isunknown(status)) seen_status[status]++;
			end
		end
	end

	// Each request but append on an empty list: all flagged but clear and the unused kind.
	task automatic test_empty_list();
		idle_pct = 0;
		send_cmd(K_READ, '0, '0, '0);
		send_cmd(K_WRITE, '0, '0, '1);
		send_cmd(K_REMOVE, '0, '0, '0);
		send_cmd(K_RANGE, '0, '0, '0);
		send_cmd(K_LAST, '0, '0, '0);
		send_cmd(K_CLEAR, '0, '0, '0);
		send_cmd(K_UNUSED, '0, '0, '0);
	endtask

	// Each operation on a short list, with the bad-index and bad-range cases.
	task automatic test_basic_ops();
		idle_pct = 0;
		send_cmd(K_APPEND, '0, '0, 32'h0000_0000);
		send_cmd(K_APPEND, '0, '0, 32'hFFFF_FFFF);
		send_cmd(K_APPEND, '0, '0, 32'hA5A5_5A5A);
		send_cmd(K_READ, 10'd0, '0, '0);
		send_cmd(K_READ, 10'd2, '0, '0);
		send_cmd(K_WRITE, 10'd1, '0, 32'h0000_0001);
		send_cmd(K_READ, 10'd1, '0, '0);
		send_cmd(K_READ, 10'd3, '0, '0);
		send_cmd(K_READ, '1, '0, '0);
		send_cmd(K_WRITE, 10'd3, '0, 32'hDEAD_BEEF);
		send_cmd(K_LAST, '0, '0, '0);
		send_cmd(K_REMOVE, 10'd0, '0, '0);
		// start past end, then end past count, then the whole list
		send_cmd(K_RANGE, 10'd1, 10'd0, '0);
		send_cmd(K_RANGE, 10'd0, 10'd2, '0);
		send_cmd(K_RANGE, 10'd0, 10'd1, '0);
		send_cmd(K_APPEND, '0, '0, 32'h8000_0000);
		send_cmd(K_APPEND, '0, '0, 32'h7FFF_FFFF);
		send_cmd(K_REMOVE, '1, '0, '0);
		send_cmd(K_RANGE, '1, '1, '0);
		send_cmd(K_RANGE, '0, '1, '0);
		send_cmd(K_UNUSED, '1, '1, '1);
		send_cmd(K_LAST, '0, '0, '0);
		send_cmd(K_CLEAR, '0, '0, '0);
		send_cmd(K_LAST, '0, '0, '0);
	endtask

	// Fill the store, hit the full flag, and work at the far end of the row.
	task automatic test_full_store();
		int n;
		idle_pct = 0;
		for (n = 0; n < LIST_CAP; n++) begin
			send_cmd(K_APPEND, '0, '0, $urandom());
		end
		send_cmd(K_APPEND, '0, '0, 32'h1234_5678);
		send_cmd(K_READ, '1, '0, '0);
		send_cmd(K_LAST, '0, '0, '0);
		send_cmd(K_WRITE, '1, '0, 32'hCAFE_F00D);
		send_cmd(K_READ, '1, '0, '0);
		send_cmd(K_REMOVE, '1, '0, '0);
		send_cmd(K_APPEND, '0, '0, 32'h5555_AAAA);
		send_cmd(K_RANGE, 10'd0, 10'd1022, '0);
		send_cmd(K_READ, 10'd0, '0, '0);
		send_cmd(K_CLEAR, '0, '0, '0);
		wait_results_drained();
	endtask

	// Random traffic: mostly valid indices into a short list, some stray ones.
	task automatic test_random_traffic(input int n, input int pct);
		int j;
		int r;
		int lo;
		int hi;
		logic [2:0] op;
		logic [IDX_W-1:0] at;
		logic [IDX_W-1:0] at_end;
		logic [DATA_W-1:0] word;
		idle_pct = pct;
		for (j = 0; j < n; j++) begin
			r = $urandom_range(99, 0);
			if (list_len > SOFT_LEN) op = K_CLEAR;
			else if (r < 30) op = K_APPEND;
			else if (r < 48) op = K_READ;
			else if (r < 62) op = K_WRITE;
			else if (r < 76) op = K_REMOVE;
			else if (r < 88) op = K_RANGE;
			else if (r < 96) op = K_LAST;
			else if (r < 98) op = K_CLEAR;
			else op = K_UNUSED;

			word = $urandom();
			if ($urandom_range(9, 0) == 0) word = $urandom_range(1, 0) ? '1 : '0;

			at     = $urandom();
			at_end = $urandom();
			if (list_len != 0 && $urandom_range(9, 0) < 8) begin
				lo = $urandom_range(list_len - 1, 0);
				hi = lo + $urandom_range(5, 0);
				if (hi > list_len - 1) hi = list_len - 1;
				// now and then break the range: reversed or running off the end
				r = $urandom_range(7, 0);
				if (r == 0 && lo > 0) hi = lo - 1;
				else if (r == 1) hi = list_len;
				at     = IDX_W'(lo);
				at_end = IDX_W'(hi);
			end

			if ($urandom_range(99, 0) == 0) wait_results_drained();
			send_cmd(op, at, at_end, word);
		end
		wait_results_drained();
	endtask

	initial begin
		// Drive every input before the first edge and hold reset.
		arst_n          = 1'b0;
		start           = 1'b0;
		kind            = '0;
		index           = '0;
		index_end       = '0;
		value           = '0;
		idle_pct        = 0;
		err_count       = 0;
		requests_sent   = 0;
		results_checked = 0;
		list_len        = 0;
		foreach (seen_status[s]) seen_status[s] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_empty_list();
		test_basic_ops();
		test_full_store();
		// Back to back, heavy sender gaps, back to back again, light gaps.
		test_random_traffic(150, 0);
		test_random_traffic(150, 87);
		test_random_traffic(150, 0);
		test_random_traffic(150, 17);

		// Let any stray strobe show up before judging.
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests over all seven kinds plus the unused code; %0d results checked.",
			requests_sent, results_checked);
		$display("Status seen: ok %0d, out of range %0d, full %0d, empty %0d.",
			seen_status[ST_OK], seen_status[ST_RANGE], seen_status[ST_FULL],
			seen_status[ST_EMPTY]);
		if (err_count == 0) begin
			$display("[indexed_list_store] OK");
		end else begin
			$display("[indexed_list_store] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_ctrl.sv
rtl/indexed_list_store.sv
tb/sv/tb.sv
